/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL of the LZSS stream decompressor.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must never hold outside reset.
`define LZSS_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// Antecedent implies consequent in the same cycle, outside reset.
`define LZSS_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* rtl/lzss_pkg.sv */
// Shared constants and types of the LZSS stream decompressor.
// No dependencies; used by every RTL file of the block but lzss_ram.
package lzss_pkg;

  localparam int WIN_DEPTH  = 4096;
  localparam int WIN_AW     = $clog2(WIN_DEPTH);
  localparam int BYTE_W     = 8;
  localparam int CNT_W      = 32;
  localparam int LEN_W      = 5;
  localparam int LEN_BIAS   = 3;
  localparam int FLAG_COUNT = 8;
  localparam int FLAG_CW    = 4;
  localparam int CFG_AW     = 2;
  localparam int CFG_DW     = 32;

  typedef enum logic [1:0] {
    PH_FLAG,
    PH_TOKEN,
    PH_MATCH_HI
  } lzss_phase_t;

  typedef struct packed {
    logic clearing;
    logic copy_busy;
  } lzss_stat_t;

endpackage

/* rtl/lzss_if.sv */
// Valid/ready stream interfaces for compressed input and decompressed output.
// Depends on lzss_pkg for the payload widths.
interface lzss_in_if;
  logic                      valid;
  logic                      ready;
  logic [lzss_pkg::BYTE_W-1:0] in_byte;
  logic                      in_last;

  modport source (output valid, in_byte, in_last, input ready);
  modport sink   (input valid, in_byte, in_last, output ready);
endinterface

interface lzss_out_if;
  logic                      valid;
  logic                      ready;
  logic [lzss_pkg::BYTE_W-1:0] out_byte;
  logic                      run_end;
  logic                      stream_done;

  modport source (output valid, out_byte, run_end, stream_done, input ready);
  modport sink   (input valid, out_byte, run_end, stream_done, output ready);
endinterface

/* rtl/lzss_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies; read during write to the same address returns old data.
module lzss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

/* rtl/lzss_cfg.sv */
// APB-style configuration register holding the output length.
// Depends on lzss_pkg.
module lzss_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lzss_pkg::CFG_AW-1:0] paddr,
  input  logic [lzss_pkg::CFG_DW-1:0] pwdata,
  output logic [lzss_pkg::CFG_DW-1:0] prdata,
  output logic                        pready,
  output logic [lzss_pkg::CNT_W-1:0]  olen
);
  import lzss_pkg::*;

  logic [CNT_W-1:0] olen_r;
  logic             wr_en;

  // Single register: word address bits are not decoded.
  assign wr_en  = psel && penable && pwrite && (paddr[CFG_AW-1] == paddr[CFG_AW-1]);
  assign pready = 1'b1;
  assign prdata = olen_r;
  assign olen   = olen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      olen_r <= '0;
    end else if (wr_en) begin
      olen_r <= pwdata;
    end
  end

endmodule

/* rtl/lzss_core.sv */
// Token parser, history copy engine, clearing pass and output register.
// Depends on lzss_pkg and lzss_if; drives the ports of one history RAM.
module lzss_core (
  input  logic                         clk,
  input  logic                         rst_n,
  lzss_in_if.sink                      in_ch,
  lzss_out_if.source                   out_ch,
  input  logic [lzss_pkg::CNT_W-1:0]   olen,
  output logic                         ram_we,
  output logic [lzss_pkg::WIN_AW-1:0]  ram_waddr,
  output logic [lzss_pkg::BYTE_W-1:0]  ram_wdata,
  output logic                         ram_re,
  output logic [lzss_pkg::WIN_AW-1:0]  ram_raddr,
  input  logic [lzss_pkg::BYTE_W-1:0]  ram_rdata,
  output lzss_pkg::lzss_stat_t         stat
);
  import lzss_pkg::*;

  lzss_phase_t        phase_r, phase_nxt;
  logic [BYTE_W-1:0]  flags_r, flags_nxt;
  logic [FLAG_CW-1:0] flags_left_r, flags_left_nxt;
  logic [BYTE_W-1:0]  low_r, low_nxt;
  logic [WIN_AW-1:0]  wp_r, wp_nxt;
  logic [CNT_W-1:0]   produced_r, produced_nxt;
  logic               clr_r, clr_nxt;
  logic [WIN_AW-1:0]  clr_addr_r, clr_addr_nxt;
  logic [WIN_AW-1:0]  rd_r, rd_nxt;
  logic [LEN_W-1:0]   iss_left_r, iss_left_nxt;
  logic [LEN_W-1:0]   cons_left_r, cons_left_nxt;
  logic               pend_r, pend_nxt;
  logic               end_pend_r, end_pend_nxt;
  logic               fwd_hit_r, fwd_hit_nxt;
  logic [BYTE_W-1:0]  fwd_data_r, fwd_data_nxt;
  logic               ov_r, ov_nxt;
  logic [BYTE_W-1:0]  ob_r, ob_nxt;
  logic               orun_r, orun_nxt;
  logic               odone_r, odone_nxt;

  logic               slot_free;
  logic               accept;
  logic               consume;
  logic               issue;
  logic               done_now;
  logic               below_limit;
  logic               last_byte;
  logic [BYTE_W-1:0]  cbyte;

  assign slot_free   = !ov_r || out_ch.ready;
  assign in_ch.ready = !clr_r && (cons_left_r == '0) && slot_free;
  assign accept      = in_ch.valid && in_ch.ready;
  assign below_limit = produced_r < olen;
  assign done_now    = ({1'b0, produced_r} + 33'd1) == {1'b0, olen};
  assign cbyte       = fwd_hit_r ? fwd_data_r : ram_rdata;
  assign consume     = pend_r && slot_free;
  assign last_byte   = (cons_left_r == LEN_W'(1)) || done_now;
  assign issue       = (iss_left_r != '0) && (!pend_r || consume) && !(consume && done_now);

  assign out_ch.valid       = ov_r;
  assign out_ch.out_byte    = ob_r;
  assign out_ch.run_end     = orun_r;
  assign out_ch.stream_done = odone_r;
  assign stat.clearing      = clr_r;
  assign stat.copy_busy     = cons_left_r != '0;

  always_comb begin
    phase_nxt      = phase_r;
    flags_nxt      = flags_r;
    flags_left_nxt = flags_left_r;
    low_nxt        = low_r;
    wp_nxt         = wp_r;
    produced_nxt   = produced_r;
    clr_nxt        = clr_r;
    clr_addr_nxt   = clr_addr_r;
    rd_nxt         = rd_r;
    iss_left_nxt   = iss_left_r;
    cons_left_nxt  = cons_left_r;
    pend_nxt       = pend_r;
    end_pend_nxt   = end_pend_r;
    fwd_hit_nxt    = fwd_hit_r;
    fwd_data_nxt   = fwd_data_r;
    ov_nxt         = ov_r && !out_ch.ready;
    ob_nxt         = ob_r;
    orun_nxt       = orun_r;
    odone_nxt      = odone_r;
    ram_we         = 1'b0;
    ram_waddr      = wp_r;
    ram_wdata      = cbyte;
    ram_re         = 1'b0;
    ram_raddr      = rd_r;

    // Zero the history after reset, one entry a cycle.
    if (clr_r) begin
      ram_we       = 1'b1;
      ram_waddr    = clr_addr_r;
      ram_wdata    = '0;
      clr_addr_nxt = clr_addr_r + WIN_AW'(1);
      if (clr_addr_r == WIN_AW'(WIN_DEPTH - 1)) begin
        clr_nxt = 1'b0;
      end
    end

    // Copy engine: write back and emit the byte from the pending read.
    if (consume) begin
      ram_we        = 1'b1;
      ov_nxt        = 1'b1;
      ob_nxt        = cbyte;
      orun_nxt      = last_byte;
      odone_nxt     = done_now;
      wp_nxt        = wp_r + WIN_AW'(1);
      produced_nxt  = produced_r + CNT_W'(1);
      cons_left_nxt = cons_left_r - LEN_W'(1);
      pend_nxt      = 1'b0;
      if (last_byte) begin
        cons_left_nxt = '0;
        iss_left_nxt  = '0;
        if (end_pend_r) begin
          wp_nxt       = '0;
          produced_nxt = '0;
          end_pend_nxt = 1'b0;
        end
      end
    end

    // Copy engine: read the next source byte, forward a same-address write.
    if (issue) begin
      ram_re       = 1'b1;
      rd_nxt       = rd_r + WIN_AW'(1);
      iss_left_nxt = iss_left_r - LEN_W'(1);
      pend_nxt     = 1'b1;
      fwd_hit_nxt  = consume && (wp_r == rd_r);
      fwd_data_nxt = cbyte;
    end

    if (accept) begin
      unique case (phase_r)
        PH_FLAG: begin
          flags_nxt      = in_ch.in_byte;
          flags_left_nxt = FLAG_CW'(FLAG_COUNT);
          phase_nxt      = PH_TOKEN;
        end
        PH_TOKEN: begin
          if (flags_r[0]) begin
            low_nxt   = in_ch.in_byte;
            phase_nxt = PH_MATCH_HI;
          end else begin
            if (below_limit) begin
              ram_we       = 1'b1;
              ram_waddr    = wp_r;
              ram_wdata    = in_ch.in_byte;
              ov_nxt       = 1'b1;
              ob_nxt       = in_ch.in_byte;
              orun_nxt     = 1'b1;
              odone_nxt    = done_now;
              wp_nxt       = wp_r + WIN_AW'(1);
              produced_nxt = produced_r + CNT_W'(1);
            end
            flags_nxt      = flags_r >> 1;
            flags_left_nxt = flags_left_r - FLAG_CW'(1);
            phase_nxt      = (flags_left_r == FLAG_CW'(1)) ? PH_FLAG : PH_TOKEN;
          end
        end
        PH_MATCH_HI: begin
          if (below_limit) begin
            cons_left_nxt = {1'b0, in_ch.in_byte[7:4]} + LEN_W'(LEN_BIAS);
            iss_left_nxt  = {1'b0, in_ch.in_byte[7:4]} + LEN_W'(LEN_BIAS);
            rd_nxt        = wp_r - {in_ch.in_byte[3:0], low_r} - WIN_AW'(1);
            end_pend_nxt  = in_ch.in_last;
          end
          flags_nxt      = flags_r >> 1;
          flags_left_nxt = flags_left_r - FLAG_CW'(1);
          phase_nxt      = (flags_left_r == FLAG_CW'(1)) ? PH_FLAG : PH_TOKEN;
        end
        default: begin
          phase_nxt = PH_FLAG;
        end
      endcase

      // Stream end: drop the parser; a running copy clears the pointers later.
      if (in_ch.in_last) begin
        phase_nxt      = PH_FLAG;
        flags_nxt      = '0;
        flags_left_nxt = '0;
        low_nxt        = '0;
        if (!(phase_r == PH_MATCH_HI && below_limit)) begin
          wp_nxt       = '0;
          produced_nxt = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_FLAG;
      flags_r      <= '0;
      flags_left_r <= '0;
      low_r        <= '0;
      wp_r         <= '0;
      produced_r   <= '0;
      clr_r        <= 1'b1;
      clr_addr_r   <= '0;
      iss_left_r   <= '0;
      cons_left_r  <= '0;
      pend_r       <= 1'b0;
      end_pend_r   <= 1'b0;
      fwd_hit_r    <= 1'b0;
      ov_r         <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      flags_r      <= flags_nxt;
      flags_left_r <= flags_left_nxt;
      low_r        <= low_nxt;
      wp_r         <= wp_nxt;
      produced_r   <= produced_nxt;
      clr_r        <= clr_nxt;
      clr_addr_r   <= clr_addr_nxt;
      iss_left_r   <= iss_left_nxt;
      cons_left_r  <= cons_left_nxt;
      pend_r       <= pend_nxt;
      end_pend_r   <= end_pend_nxt;
      fwd_hit_r    <= fwd_hit_nxt;
      ov_r         <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_r       <= rd_nxt;
    fwd_data_r <= fwd_data_nxt;
    ob_r       <= ob_nxt;
    orun_r     <= orun_nxt;
    odone_r    <= odone_nxt;
  end

endmodule

/* rtl/lzss_stream_decompressor.sv */
// LZSS stream decompressor with a 4096-byte history: one compressed byte per
// input transfer, one decompressed byte per output transfer. After reset the
// block zeroes its history in a clearing pass and accepts no input until it
// ends; configuration writes are taken throughout. A flag byte or a literal
// holds the input only under output back-pressure. A match byte pair of length
// N (3 to 18) holds the input after its second byte until its copy ends: the
// copy reads one history byte and writes one back each cycle while the output
// accepts, through the single-write, single-read history RAM with its
// registered read. Output back-pressure stalls the copy.
// Depends on lzss_pkg, lzss_if, lzss_cfg, lzss_core, lzss_ram, assert_macros.svh.
`include "assert_macros.svh"

module lzss_stream_decompressor (
  input  logic                        clk,
  input  logic                        rst_n,
  lzss_in_if.sink                     in_ch,
  lzss_out_if.source                  out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lzss_pkg::CFG_AW-1:0] paddr,
  input  logic [lzss_pkg::CFG_DW-1:0] pwdata,
  output logic [lzss_pkg::CFG_DW-1:0] prdata,
  output logic                        pready
);
  import lzss_pkg::*;

  logic [CNT_W-1:0]  olen;
  logic              ram_we;
  logic [WIN_AW-1:0] ram_waddr;
  logic [BYTE_W-1:0] ram_wdata;
  logic              ram_re;
  logic [WIN_AW-1:0] ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;
  lzss_stat_t        stat;

  // Output length register on the configuration port.
  lzss_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .olen    (olen)
  );

  // Parser, copy engine and output register.
  lzss_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .olen      (olen),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .stat      (stat)
  );

  // History window; the core forwards a write that hits the address being read.
  lzss_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (WIN_DEPTH)
  ) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Hold input while the history is being zeroed or a copy is running.
  `LZSS_ASSERT_NEVER(a_no_in_clearing, clk, rst_n, stat.clearing && in_ch.ready, "input ready during clear")
  `LZSS_ASSERT_NEVER(a_no_in_copy, clk, rst_n, stat.copy_busy && in_ch.ready, "input ready during copy")
  // The byte that reaches the output length always closes its run.
  `LZSS_ASSERT_IMPLIES(a_done_ends_run, clk, rst_n, out_ch.valid && out_ch.stream_done, out_ch.run_end, "stream_done without run_end")

endmodule
